/* rtl/core/bsm_pkg.sv */
// Package for the bounding sphere merge unit: shared widths and merge case codes.
// Depends on nothing.
`default_nettype none
package bsm_pkg;
	localparam int COORD_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam logic [1:0] CASE_FIRST  = 2'd0;
	localparam logic [1:0] CASE_SECOND = 2'd1;
	localparam logic [1:0] CASE_NEW    = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/bsm_sqrt_stage.sv */
// One pipelined step of a restoring integer square root (one result bit).
// Depends on bsm_pkg.
`default_nettype none
module bsm_sqrt_stage #(
	parameter int NW  = 66,
	parameter int RW  = 33,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] rad_in,
	input  wire logic [RW-1:0] root_in,
	output logic      [NW-1:0] rad_out,
	output logic      [RW-1:0] root_out
);
	import bsm_pkg::*;
	logic [NW+1:0] trial;
	logic [NW+1:0] rem_in;
	always_comb begin
		rem_in = {2'b00, rad_in};
		trial  = ({{(NW+2-RW){1'b0}}, root_in} << (BIT + 1))
			+ ({{(NW+1){1'b0}}, 1'b1} << (2 * BIT));
	end
	always_ff @(posedge clk) begin
		if (trial <= rem_in) begin
			rad_out  <= NW'(rem_in - trial);
			root_out <= root_in | (RW'(1) << BIT);
		end else begin
			rad_out  <= rad_in;
			root_out <= root_in;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bsm_div_stage.sv */
// One pipelined step of a restoring divider (one quotient bit).
// Depends on bsm_pkg.
`default_nettype none
module bsm_div_stage #(
	parameter int NW  = 100,
	parameter int DW  = 35,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] rem_in,
	input  wire logic [DW-1:0] den,
	input  wire logic [NW-1:0] quo_in,
	output logic      [NW-1:0] rem_out,
	output logic      [NW-1:0] quo_out
);
	import bsm_pkg::*;
	logic [NW+DW-1:0] shifted;
	always_comb shifted = {{DW{1'b0}}, den} << BIT;
	always_ff @(posedge clk) begin
		if ({{DW{1'b0}}, rem_in} >= shifted) begin
			rem_out <= NW'({{DW{1'b0}}, rem_in} - shifted);
			quo_out <= quo_in | (NW'(1) << BIT);
		end else begin
			rem_out <= rem_in;
			quo_out <= quo_in;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bounding_sphere_merge_unit.sv */
// Bounding sphere merge: smallest sphere enclosing two spheres, pipelined.
// Pipeline: 3 front stages, COORD_WIDTH+1 root stages, 2 product stages,
// 2*COORD_WIDTH+4 divide stages, 1 output stage.
// Throughput: one pair per cycle; set by the fully unrolled root and divide pipelines.
// Reset clears the valid bits only; the receiver cannot stall, so busy stays low.
// Depends on bsm_pkg, bsm_sqrt_stage, bsm_div_stage.
`default_nettype none
module bounding_sphere_merge_unit #(
	parameter int COORD_WIDTH   = bsm_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = bsm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] first_x,
	input  wire logic signed [COORD_WIDTH-1:0] first_y,
	input  wire logic signed [COORD_WIDTH-1:0] first_z,
	input  wire logic        [COORD_WIDTH-2:0] first_radius,
	input  wire logic signed [COORD_WIDTH-1:0] second_x,
	input  wire logic signed [COORD_WIDTH-1:0] second_y,
	input  wire logic signed [COORD_WIDTH-1:0] second_z,
	input  wire logic        [COORD_WIDTH-2:0] second_radius,
	output logic                               done,
	output logic signed      [COORD_WIDTH-1:0] merged_x,
	output logic signed      [COORD_WIDTH-1:0] merged_y,
	output logic signed      [COORD_WIDTH-1:0] merged_z,
	output logic             [COORD_WIDTH-2:0] merged_radius,
	output logic             [1:0]             merge_case
);
	import bsm_pkg::*;
	localparam int W   = COORD_WIDTH;
	localparam int MW  = W;
	localparam int SQW = 2 * MW;
	localparam int D2W = SQW + 2;
	localparam int RTW = D2W / 2;
	localparam int KW  = RTW + 2;
	localparam int PW  = MW + KW + 1;
	localparam int DNW = RTW + 1;
	localparam int NS  = RTW;
	localparam int ND  = PW;
	localparam int LAT = 3 + NS + 2 + ND + 1;
	localparam int FB  = FRACTION_BITS;

	typedef struct packed {
		logic signed [W-1:0] ax, ay, az;
		logic        [W-2:0] ar, br;
		logic signed [W-1:0] bx, by, bz;
		logic [2:0]          neg;
		logic [MW-1:0]       mx, my, mz;
	} item_t;

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[LAT-2:0], start};
	end
	assign busy = 1'b0;
	assign done = vld_q[LAT-1] && (FB >= 0);

	// stage 1: differences
	item_t it_s1;
	always_ff @(posedge clk) begin
		logic signed [W:0] dx, dy, dz;
		dx = {second_x[W-1], second_x} - {first_x[W-1], first_x};
		dy = {second_y[W-1], second_y} - {first_y[W-1], first_y};
		dz = {second_z[W-1], second_z} - {first_z[W-1], first_z};
		it_s1.ax <= first_x;  it_s1.ay <= first_y;  it_s1.az <= first_z;
		it_s1.bx <= second_x; it_s1.by <= second_y; it_s1.bz <= second_z;
		it_s1.ar <= first_radius; it_s1.br <= second_radius;
		it_s1.neg <= {dz[W], dy[W], dx[W]};
		it_s1.mx <= dx[W] ? MW'(-dx) : MW'(dx);
		it_s1.my <= dy[W] ? MW'(-dy) : MW'(dy);
		it_s1.mz <= dz[W] ? MW'(-dz) : MW'(dz);
	end

	// stage 2: squares
	item_t it_s2;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2, rd_s2;
	logic           ge_s2;
	always_ff @(posedge clk) begin
		logic [W-2:0] rd;
		rd = (it_s1.ar >= it_s1.br) ? it_s1.ar - it_s1.br : it_s1.br - it_s1.ar;
		it_s2 <= it_s1;
		sx_s2 <= it_s1.mx * it_s1.mx;
		sy_s2 <= it_s1.my * it_s1.my;
		sz_s2 <= it_s1.mz * it_s1.mz;
		rd_s2 <= SQW'(rd) * SQW'(rd);
		ge_s2 <= it_s1.ar >= it_s1.br;
	end

	// stage 3: sum and containment
	item_t it_s3;
	logic [D2W-1:0] d2_s3;
	logic [1:0]     cs_s3;
	always_ff @(posedge clk) begin
		logic [D2W-1:0] d2;
		logic           le;
		d2 = D2W'(sx_s2) + D2W'(sy_s2) + D2W'(sz_s2);
		le = d2 <= D2W'(rd_s2);
		it_s3 <= it_s2;
		d2_s3 <= d2;
		if (le && ge_s2) cs_s3 <= CASE_FIRST;
		else if (le && (it_s2.ar == it_s2.br || !ge_s2)) cs_s3 <= CASE_SECOND;
		else cs_s3 <= CASE_NEW;
	end

	// square root pipeline
	item_t          sit  [0:NS];
	logic [1:0]     scs  [0:NS];
	logic [D2W-1:0] srad [0:NS];
	logic [RTW-1:0] sroot[0:NS];
	assign sit[0] = it_s3; assign scs[0] = cs_s3;
	assign srad[0] = d2_s3; assign sroot[0] = '0;
	for (genvar g = 0; g < NS; g++) begin : g_sq
		bsm_sqrt_stage #(.NW(D2W), .RW(RTW), .BIT(NS-1-g)) u_sq (
			.clk(clk), .rad_in(srad[g]), .root_in(sroot[g]),
			.rad_out(srad[g+1]), .root_out(sroot[g+1]));
		always_ff @(posedge clk) begin
			sit[g+1] <= sit[g]; scs[g+1] <= scs[g];
		end
	end

	// stage: round root up, offset factor
	item_t          it_k;
	logic [1:0]     cs_k;
	logic [RTW-1:0] dist_k;
	logic [KW-1:0]  k_k;
	always_ff @(posedge clk) begin
		logic [RTW-1:0] root_up;
		root_up = sroot[NS] + RTW'(srad[NS] != '0);
		it_k <= sit[NS]; cs_k <= scs[NS]; dist_k <= root_up;
		k_k <= KW'(root_up) + KW'(sit[NS].br) - KW'(sit[NS].ar);
	end

	// stage: products for the divide
	item_t          it_p;
	logic [1:0]     cs_p;
	logic [RTW-1:0] dist_p;
	logic [PW-1:0]  nx_p, ny_p, nz_p;
	always_ff @(posedge clk) begin
		it_p <= it_k; cs_p <= cs_k; dist_p <= dist_k;
		nx_p <= PW'(it_k.mx) * PW'(k_k) + PW'(dist_k);
		ny_p <= PW'(it_k.my) * PW'(k_k) + PW'(dist_k);
		nz_p <= PW'(it_k.mz) * PW'(k_k) + PW'(dist_k);
	end

	// divide pipelines, three lanes sharing the denominator
	item_t          dit [0:ND];
	logic [1:0]     dcs [0:ND];
	logic [RTW-1:0] ddst[0:ND];
	logic [PW-1:0]  rx[0:ND], ry[0:ND], rz[0:ND], qx[0:ND], qy[0:ND], qz[0:ND];
	assign dit[0] = it_p; assign dcs[0] = cs_p; assign ddst[0] = dist_p;
	assign rx[0] = nx_p; assign ry[0] = ny_p; assign rz[0] = nz_p;
	assign qx[0] = '0; assign qy[0] = '0; assign qz[0] = '0;
	for (genvar g = 0; g < ND; g++) begin : g_dv
		logic [DNW-1:0] den;
		assign den = {ddst[g], 1'b0};
		bsm_div_stage #(.NW(PW), .DW(DNW), .BIT(ND-1-g)) u_dx (.clk(clk),
			.rem_in(rx[g]), .den(den), .quo_in(qx[g]), .rem_out(rx[g+1]), .quo_out(qx[g+1]));
		bsm_div_stage #(.NW(PW), .DW(DNW), .BIT(ND-1-g)) u_dy (.clk(clk),
			.rem_in(ry[g]), .den(den), .quo_in(qy[g]), .rem_out(ry[g+1]), .quo_out(qy[g+1]));
		bsm_div_stage #(.NW(PW), .DW(DNW), .BIT(ND-1-g)) u_dz (.clk(clk),
			.rem_in(rz[g]), .den(den), .quo_in(qz[g]), .rem_out(rz[g+1]), .quo_out(qz[g+1]));
		always_ff @(posedge clk) begin
			dit[g+1] <= dit[g]; dcs[g+1] <= dcs[g]; ddst[g+1] <= ddst[g];
		end
	end

	// output stage
	function automatic logic signed [W-1:0] place(input logic signed [W-1:0] a,
			input logic [PW-1:0] q, input logic n);
		logic signed [PW+1:0] v;
		logic signed [PW+1:0] mx, mn;
		mx = (PW+2)'((W-1)'('1));
		mn = -mx - 1;
		v = n ? (PW+2)'(a) - $signed({2'b00, q}) : (PW+2)'(a) + $signed({2'b00, q});
		if (v > mx) return W'(mx);
		if (v < mn) return W'(mn);
		return W'(v);
	endfunction

	always_ff @(posedge clk) begin
		logic [RTW+1:0] rs;
		item_t          it;
		it = dit[ND];
		rs = RTW'(0) + (RTW+2)'(ddst[ND]) + (RTW+2)'(it.ar) + (RTW+2)'(it.br) + 1'b1;
		merge_case <= dcs[ND];
		case (dcs[ND])
			CASE_FIRST: begin
				merged_x <= it.ax; merged_y <= it.ay; merged_z <= it.az;
				merged_radius <= it.ar;
			end
			CASE_SECOND: begin
				merged_x <= it.bx; merged_y <= it.by; merged_z <= it.bz;
				merged_radius <= it.br;
			end
			default: begin
				merged_x <= place(it.ax, qx[ND], it.neg[0]);
				merged_y <= place(it.ay, qy[ND], it.neg[1]);
				merged_z <= place(it.az, qz[ND], it.neg[2]);
				merged_radius <= ((rs >> 1) > (RTW+2)'((W-1)'('1))) ? '1 : (W-1)'(rs >> 1);
			end
		endcase
	end
endmodule
`default_nettype wire
